// File: design/rsi_pkg.sv
// shared widths, constants and divider control types for the rsi block
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_BITS      = PRICE_BITS + FRACTION_BITS;
  localparam int RSI_BITS      = 23;
  localparam int PER_BITS      = 8;
  localparam int MUL_BITS      = AVG_BITS + PER_BITS;
  localparam int SUM_BITS      = MUL_BITS + 1;
  localparam int RSI_WIDE      = MUL_BITS + FRACTION_BITS;
  localparam int DIV_BITS      = AVG_BITS + 1;
  localparam int CNT_BITS      = $clog2(AVG_BITS + 1);

  localparam logic [PER_BITS-1:0] PER_RESET = PER_BITS'(14);
  localparam logic [PER_BITS-1:0] RSI_SCALE = PER_BITS'(100);
  localparam logic [RSI_BITS-1:0] RSI_FULL  = RSI_BITS'(100 << FRACTION_BITS);
  localparam logic [RSI_BITS-1:0] RSI_HALF  = RSI_BITS'(50 << FRACTION_BITS);

  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/relative_strength_index.sv
// wilder rsi sequencer around one shared multiplier and one serial divider
//
// usage:
//   price requests come in on in_valid/in_ready, one result request
//   (rsi_value, is_ready) goes out on out_valid/out_ready for every price.
//   smoothing_period is written on cfg_valid/cfg_ready (always ready), by the
//   user only while the block is idle, which the block does not enforce;
//   zero acts as one. the first price after reset is only stored and answers
//   50 with is_ready low; later prices update the average gain and loss and
//   produce 100*G/(G+L) with 16 fraction bits.
// sequence:
//   a first price goes from idle through S_FIN into the output register.
//   a later price runs two average updates (multiply, load, 48 divider
//   steps, done) and then the rsi quotient (multiply, load, 23 steps)
//   before the output step; with zero average loss the rsi divide is
//   skipped. the divider produces one quotient bit per cycle.
//   in_ready is high only when the sequencer is idle, so one price is worked on at a time.
// reset: synchronous; period returns to 14, all history is cleared.
// stall: a result waits in the output register; the next price may be
//   accepted and worked on, and its result holds until out_ready frees it.
`timescale 1ns / 1ps

module relative_strength_index (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rsi_pkg::PRICE_BITS-1:0]     price,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rsi_pkg::RSI_BITS-1:0]       rsi_value,
  output logic                               is_ready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsi_pkg::PER_BITS-1:0]       smoothing_period
);
  import rsi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL   = 8'b00000010,
    S_LOAD  = 8'b00000100,
    S_DIV   = 8'b00001000,
    S_RMUL  = 8'b00010000,
    S_RLOAD = 8'b00100000,
    S_RDIV  = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t                state;
  logic [PER_BITS-1:0]   period;
  logic [PRICE_BITS-1:0] last_price;
  logic                  have_last;
  logic [AVG_BITS-1:0]   avg_gain;
  logic [AVG_BITS-1:0]   avg_loss;
  logic [PER_BITS-1:0]   warm_cnt;
  logic                  warm;
  logic                  sel_loss;
  logic [AVG_BITS-1:0]   step_gain;
  logic [AVG_BITS-1:0]   step_loss;
  logic [MUL_BITS-1:0]   prod;
  logic [RSI_BITS-1:0]   res_rsi;

  logic [PER_BITS-1:0]   per;
  logic [PER_BITS-1:0]   cnt_inc;
  logic [AVG_BITS-1:0]   mul_a;
  logic [PER_BITS-1:0]   mul_k;
  logic [PER_BITS:0]     avg_div;
  logic [SUM_BITS-1:0]   sum;
  logic [RSI_WIDE-1:0]   rsi_num;
  logic [PRICE_BITS-1:0] delta;
  logic                  rising;

  div_req_t              div_req;
  div_stat_t             div_stat;
  logic [DIV_BITS-1:0]   div_rem;
  logic [AVG_BITS-1:0]   div_low;
  logic [DIV_BITS-1:0]   div_den;
  logic [AVG_BITS-1:0]   div_quo;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    per     = (period == '0) ? PER_BITS'(1) : period;
    cnt_inc = warm_cnt + PER_BITS'(1);
    rising  = (price >= last_price);
    delta   = rising ? (price - last_price) : (last_price - price);

    // shared multiplier operands
    mul_a = (sel_loss && state != S_RMUL) ? avg_loss : avg_gain;
    if (state == S_RMUL) begin
      mul_k = RSI_SCALE;
    end else if (warm) begin
      mul_k = per - PER_BITS'(1);
    end else begin
      mul_k = warm_cnt;
    end

    avg_div = warm ? {1'b0, per} : ({1'b0, warm_cnt} + (PER_BITS+1)'(1));
    sum     = SUM_BITS'(prod) + SUM_BITS'(sel_loss ? step_loss : step_gain);
    rsi_num = {prod, {FRACTION_BITS{1'b0}}};

    div_req.start = (state == S_LOAD) || (state == S_RLOAD);
    if (state == S_RLOAD) begin
      // quotient is below 2^RSI_BITS, so only the low bits need steps
      div_req.steps = CNT_BITS'(RSI_BITS);
      div_rem       = DIV_BITS'(rsi_num >> RSI_BITS);
      div_low       = {rsi_num[RSI_BITS-1:0], {(AVG_BITS-RSI_BITS){1'b0}}};
      div_den       = DIV_BITS'(avg_gain) + DIV_BITS'(avg_loss);
    end else begin
      div_req.steps = CNT_BITS'(AVG_BITS);
      div_rem       = DIV_BITS'(sum[SUM_BITS-1:AVG_BITS]);
      div_low       = sum[AVG_BITS-1:0];
      div_den       = DIV_BITS'(avg_div);
    end
  end

  rsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      period     <= PER_RESET;
      last_price <= '0;
      have_last  <= 1'b0;
      avg_gain   <= '0;
      avg_loss   <= '0;
      warm_cnt   <= '0;
      warm       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        period <= smoothing_period;
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_price <= price;
            have_last  <= 1'b1;
            if (!have_last) begin
              res_rsi <= RSI_HALF;
              state   <= S_FIN;
            end else begin
              step_gain <= rising ? {delta, {FRACTION_BITS{1'b0}}} : '0;
              step_loss <= rising ? '0 : {delta, {FRACTION_BITS{1'b0}}};
              sel_loss  <= 1'b0;
              state     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= MUL_BITS'(mul_a) * MUL_BITS'(mul_k);
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (sel_loss) begin
              avg_loss <= div_quo;
              if (!warm) begin
                warm_cnt <= cnt_inc;
                if (cnt_inc >= per) begin
                  warm <= 1'b1;
                end
              end
              state <= S_RMUL;
            end else begin
              avg_gain <= div_quo;
              sel_loss <= 1'b1;
              state    <= S_MUL;
            end
          end
        end
        S_RMUL: begin
          if (avg_loss == '0) begin
            res_rsi <= RSI_FULL;
            state   <= S_FIN;
          end else begin
            prod  <= MUL_BITS'(mul_a) * MUL_BITS'(mul_k);
            state <= S_RLOAD;
          end
        end
        S_RLOAD: begin
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (div_stat.done) begin
            res_rsi <= div_quo[RSI_BITS-1:0];
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            rsi_value <= res_rsi;
            is_ready  <= warm;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rsi_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rsi_value <= RSI_FULL)
    else $error("rsi result above full scale");

  a_idle_divider: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("price request taken while divider runs");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV || state == S_RDIV))
    else $error("divider finished outside a wait state");

endmodule

// File: design/rsi_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rsi_div (
  input  logic                              clk,
  input  logic                              rst,
  input  rsi_pkg::div_req_t                 req,
  input  logic [rsi_pkg::DIV_BITS-1:0]      rem_init,
  input  logic [rsi_pkg::AVG_BITS-1:0]      low_init,
  input  logic [rsi_pkg::DIV_BITS-1:0]      divisor,
  output rsi_pkg::div_stat_t                stat,
  output logic [rsi_pkg::AVG_BITS-1:0]      quotient
);
  import rsi_pkg::*;

  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dreg;
  logic [AVG_BITS-1:0] low;
  logic [AVG_BITS-1:0] quo;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [DIV_BITS+1:0] diff;
  logic                fits;

  // trial subtract of the shifted partial remainder
  always_comb begin
    diff = {1'b0, rem, low[AVG_BITS-1]} - {2'b00, dreg};
    fits = !diff[DIV_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= rem_init;
        low  <= low_init;
        dreg <= divisor;
        quo  <= '0;
        cnt  <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[DIV_BITS-1:0];
        end else begin
          rem <= {rem[DIV_BITS-2:0], low[AVG_BITS-1]};
        end
        low <= {low[AVG_BITS-2:0], 1'b0};
        quo <= {quo[AVG_BITS-2:0], fits};
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < dreg)
    else $error("partial remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a finished run");

endmodule

// File: tb/testbench.sv
// testbench for the wilder rsi block: predicted rsi results checked against every output request
`timescale 1ns / 1ps

module testbench;
  import rsi_pkg::*;

  typedef struct packed {
    logic [RSI_BITS-1:0] rsi;
    logic                ready;
  } rsi_result_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PRICE_BITS-1:0] price;
  logic                  out_valid;
  logic                  out_ready;
  logic [RSI_BITS-1:0]   rsi_value;
  logic                  is_ready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PER_BITS-1:0]   smoothing_period;

  // predictor copy of the block state
  logic [PER_BITS-1:0]   period_now = PER_RESET;
  logic [PRICE_BITS-1:0] prev_price = '0;
  logic                  have_prev = 1'b0;
  logic [AVG_BITS-1:0]   avg_gain = '0;
  logic [AVG_BITS-1:0]   avg_loss = '0;
  logic [PER_BITS-1:0]   warm_count = '0;
  logic                  warm_done = 1'b0;

  // expected results in a ring, written by the sender and read by the checker
  rsi_result_t           expect_mem[1024];
  logic [9:0]            exp_wr = '0;
  logic [9:0]            exp_rd = '0;

  int errors = 0;
  int prices_sent = 0;
  int results_seen = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len = 0;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  logic [PRICE_BITS-1:0] walk_price = '0;

  relative_strength_index u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .price            (price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .rsi_value        (rsi_value),
    .is_ready         (is_ready),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .smoothing_period (smoothing_period)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("relative_strength_index test failed");
    $finish;
  end

  // receiver side: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_taken != hold_asks) begin
      hold_taken = hold_asks;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    rsi_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (exp_rd == exp_wr) begin
        $error("unexpected result request: rsi_value %0d is_ready %0b", rsi_value, is_ready);
        errors++;
      end else begin
        want = expect_mem[exp_rd];
        exp_rd = exp_rd + 10'd1;
        if (rsi_value !== want.rsi) begin
          $error("rsi_value mismatch: expected %0d, actual %0d", want.rsi, rsi_value);
          errors++;
        end
        if (is_ready !== want.ready) begin
          $error("is_ready mismatch: expected %0b, actual %0b", want.ready, is_ready);
          errors++;
        end
      end
    end
  end

  // advance the predicted state by one price and queue the rsi it gives
  task automatic rsi_predict(input logic [PRICE_BITS-1:0] p);
    logic [63:0]  gain;
    logic [63:0]  loss;
    logic [63:0]  per;
    logic [63:0]  cnt;
    logic [63:0]  acc;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    rsi_result_t  r;
    per = (period_now == '0) ? 64'd1 : {56'b0, period_now};
    gain = '0;
    loss = '0;
    if (!have_prev) begin
      prev_price = p;
      have_prev = 1'b1;
      r.rsi = RSI_HALF;
      r.ready = warm_done;
    end else begin
      if (p >= prev_price) begin
        gain = {32'b0, p} - {32'b0, prev_price};
        gain = gain << FRACTION_BITS;
      end else begin
        loss = {32'b0, prev_price} - {32'b0, p};
        loss = loss << FRACTION_BITS;
      end
      prev_price = p;
      if (!warm_done) begin
        // running mean over the warm-up changes
        cnt = {56'b0, warm_count};
        acc = {16'b0, avg_gain};
        acc = (acc * cnt + gain) / (cnt + 64'd1);
        avg_gain = acc[AVG_BITS-1:0];
        acc = {16'b0, avg_loss};
        acc = (acc * cnt + loss) / (cnt + 64'd1);
        avg_loss = acc[AVG_BITS-1:0];
        warm_count = warm_count + 8'd1;
        if ({56'b0, warm_count} >= per) warm_done = 1'b1;
      end else begin
        acc = {16'b0, avg_gain};
        acc = (acc * (per - 64'd1) + gain) / per;
        avg_gain = acc[AVG_BITS-1:0];
        acc = {16'b0, avg_loss};
        acc = (acc * (per - 64'd1) + loss) / per;
        avg_loss = acc[AVG_BITS-1:0];
      end
      if (avg_loss == '0) begin
        r.rsi = RSI_FULL;
      end else begin
        num = {80'b0, avg_gain};
        num = num * RSI_FULL;
        den = {80'b0, avg_gain};
        den = den + avg_loss;
        quo = num / den;
        r.rsi = quo[RSI_BITS-1:0];
      end
      r.ready = warm_done;
    end
    expect_mem[exp_wr] = r;
    exp_wr = exp_wr + 10'd1;
  endtask

  // entered just after a falling edge; leaves in_valid high for a following request
  task automatic send_price(input logic [PRICE_BITS-1:0] p);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    price <= p;
    do @(posedge clk); while (!in_ready);
    rsi_predict(p);
    prices_sent++;
    walk_price = p;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(input logic [PER_BITS-1:0] v);
    cfg_valid <= 1'b1;
    smoothing_period <= v;
    do @(posedge clk); while (!cfg_ready);
    period_now = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly a random walk, with jumps, repeats and the price extremes mixed in
  function automatic logic [PRICE_BITS-1:0] wander_price(input logic [PRICE_BITS-1:0] cur);
    int unsigned           pick;
    logic [PRICE_BITS-1:0] step;
    pick = $urandom_range(99);
    step = $urandom() >> $urandom_range(31, 12);
    if (pick < 8) return $urandom();
    if (pick < 12) return cur;
    if (pick < 14) return pick[0] ? '1 : '0;
    if ($urandom_range(1) == 0 && step <= cur) return cur - step;
    if (step <= ~cur) return cur + step;
    return cur - step;
  endfunction

  task automatic test_first_price();
    send_price(32'hA5A5_5A5A);
    drain_results();
  endtask

  // warm-up with the reset period, then a longer one, then zero which acts as one
  task automatic test_warmup();
    send_price(32'hA5A5_5A5A);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    send_price(32'h0000_0000);
    send_price(32'h0000_0001);
    send_price(32'h8000_0000);
    drain_results();
    write_period(8'd255);
    send_price(32'h8000_1000);
    send_price(32'h7FFF_0000);
    send_price(32'h7FFF_0000);
    drain_results();
    write_period(8'd0);
    send_price(32'h7FFE_0000);
    send_price(32'h7FFD_0000);
    send_price(32'h7FFF_FFFF);
    drain_results();
  endtask

  task automatic test_smoothing_extremes();
    write_period(8'd1);
    send_price(32'h0000_0010);
    send_price(32'h0000_0010);
    drain_results();
    write_period(8'd255);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0000);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct,
                                     input logic [PER_BITS-1:0] per);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_period(per);
    repeat (n) send_price(wander_price(walk_price));
    drain_results();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_len = 800;
    hold_asks++;
    repeat (6) send_price(wander_price(walk_price));
    drain_results();
  endtask

  task automatic test_sender_pause();
    repeat (5) send_price(wander_price(walk_price));
    drain_results();
    repeat (5) send_price(wander_price(walk_price));
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    price = '0;
    cfg_valid = 1'b0;
    smoothing_period = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle_pct = 17;
    rcv_idle_pct = 71;
    test_first_price();
    test_warmup();
    test_smoothing_extremes();
    test_random_traffic(165, 17, 71, PER_BITS'($urandom_range(254, 2)));
    test_random_traffic(165, 71, 17, PER_BITS'($urandom_range(255, 1)));
    test_random_traffic(165, 0, 0, PER_BITS'($urandom_range(40, 2)));
    test_output_stall();
    test_sender_pause();
    repeat (150) @(negedge clk);
    $display("covered %0d prices and %0d rsi results", prices_sent, results_seen);
    $display("periods 0, 1, 255 and random, price extremes, stalls on both sides, long hold-off");
    if (errors == 0) begin
      $display("relative_strength_index test passed");
    end else begin
      $display("relative_strength_index test failed");
    end
    $finish;
  end

endmodule
